// ----- rtl/rtsm_pkg.sv -----
// shared types and constants of the rain-triggered stepper mover
// no dependencies; used by the interfaces and every module of the block
package rtsm_pkg;

  // field widths
  localparam int unsigned PPR_W    = 10;
  localparam int unsigned ROUNDS_W = 7;
  localparam int unsigned TIMER_W  = 24;
  localparam int unsigned POT_W    = 12;
  localparam int unsigned PULSES_W = 17;
  localparam int unsigned PHASE_W  = 22;
  localparam int unsigned RPM_W    = 8;
  localparam int unsigned PROD_W   = RPM_W + PPR_W;
  localparam int unsigned QUO_W    = 26;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = TIMER_W;

  // speed mapping: rpm = RPM_BASE + pot * RPM_SPAN / POT_FULL
  localparam logic [RPM_W-1:0] RPM_BASE = 8'd20;
  localparam logic [RPM_W-1:0] RPM_SPAN = 8'd220;
  localparam logic [POT_W-1:0] POT_FULL = 12'd4095;
  localparam int unsigned SCALED_W = POT_W + RPM_W;

  // low time numerator; high time is a quarter of the low-time quotient
  localparam logic [QUO_W-1:0] LOW_NUMER = 26'd48000000;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PPR      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

  localparam logic [PPR_W-1:0]    PPR_RST      = 10'd200;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RST   = 7'd3;
  localparam logic [TIMER_W-1:0]  INTERVAL_RST = 24'd1000000;

  typedef struct packed {
    logic             rain_level;
    logic             button_event;
    logic [POT_W-1:0] pot_value;
  } in_beat_t;

  typedef struct packed {
    logic step_out;
    logic dir_out;
    logic motor_busy;
    logic sensing_on;
    logic rain_seen;
    logic sleep_request;
  } out_beat_t;

  // controller to datapath and divider
  typedef struct packed {
    logic mul_en;
    logic div_start;
    logic load;
  } cmd_t;

  // datapath and divider to controller
  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

// ----- rtl/rtsm_in_if.sv -----
// input channel of the stepper mover: one beat per microsecond tick
// depends on rtsm_pkg for the beat type
interface rtsm_in_if import rtsm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rtsm_out_if.sv -----
// output channel of the stepper mover: one result beat per tick
// depends on rtsm_pkg for the beat type
interface rtsm_out_if import rtsm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rtsm_div.sv -----
// iterative restoring divider: LOW_NUMER / divisor, one quotient bit a cycle
// depends on rtsm_pkg for widths and the constant numerator
module rtsm_div import rtsm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] divisor_i,
  output logic              done_o,
  output logic [QUO_W-1:0]  quo_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [PROD_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [PROD_W:0]   trial;

  // one shift-and-subtract step per cycle
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[QUO_W-1]};
    if (start_i) begin
      cnt_d = CNT_W'(QUO_W);
      rem_d = '0;
      quo_d = LOW_NUMER;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = PROD_W'(trial - {1'b0, divisor_i});
        quo_d = {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_d = trial[PROD_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

  // a fresh start never lands on a running division
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> cnt_q == '0)
    else $error("divider restarted while busy");

endmodule

// ----- rtl/rtsm_ctrl.sv -----
// controller: sequences the speed multiply, the divider and the timer load
// depends on rtsm_pkg for the command and status structs
module rtsm_ctrl import rtsm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic idle_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_LOAD
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;

  // state and registered commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_fire_i && sts_i.need_div) begin
            state_q <= S_MUL;
            cmd_q   <= cmd_t'{mul_en: 1'b1, div_start: 1'b0, load: 1'b0};
          end else begin
            cmd_q <= '0;
          end
        end
        S_MUL: begin
          state_q <= S_DIV;
          cmd_q   <= cmd_t'{mul_en: 1'b0, div_start: 1'b1, load: 1'b0};
        end
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_LOAD;
            cmd_q   <= cmd_t'{mul_en: 1'b0, div_start: 1'b0, load: 1'b1};
          end else begin
            cmd_q <= '0;
          end
        end
        S_LOAD: begin
          state_q <= S_IDLE;
          cmd_q   <= '0;
        end
        default: begin
          state_q <= S_IDLE;
          cmd_q   <= '0;
        end
      endcase
    end
  end

  assign cmd_o  = cmd_q;
  assign idle_o = (state_q == S_IDLE);

  // divider start always follows the product update
  a_start_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_q.div_start |-> $past(cmd_q.mul_en))
    else $error("divider started without a fresh product");

  // divider finishes only while waited on
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> state_q == S_DIV)
    else $error("stray divider completion");

endmodule

// ----- rtl/rtsm_dp.sv -----
// datapath: tick state, config registers, speed product and result register
// depends on rtsm_pkg; divider quotient comes from rtsm_div
module rtsm_dp import rtsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_fire_i,
  input  in_beat_t              in_beat_i,
  input  logic                  out_ready_i,
  input  cmd_t                  cmd_i,
  input  logic [QUO_W-1:0]      quo_i,
  output logic                  need_div_o,
  output logic [PROD_W-1:0]     prod_o,
  output logic                  out_valid_o,
  output out_beat_t             out_beat_o
);

  // config
  logic [PPR_W-1:0]    ppr_q;
  logic [ROUNDS_W-1:0] rounds_q;
  logic [TIMER_W-1:0]  interval_q;

  // tick state
  logic                sens_q, sens_d;
  logic                last_q, last_d;
  logic [TIMER_W-1:0]  ctmr_q, ctmr_d;
  logic                btn_q, btn_d;
  logic                act_q, act_d;
  logic                dir_q, dir_d;
  logic [PULSES_W-1:0] left_q, left_d;
  logic                hi_q, hi_d;
  logic [PHASE_W-1:0]  ptmr_q, ptmr_d;
  logic                slp_q, slp_d;
  logic [PHASE_W-1:0]  low_q;
  logic                sleep;
  logic                start;
  logic                chk_clr;
  logic                go;
  logic                go_close;
  logic                go_sleep;

  // speed
  logic [SCALED_W-1:0] scaled;
  logic [RPM_W-1:0]    q0;
  logic [POT_W:0]      r0;
  logic [RPM_W-1:0]    rpm_d, rpm_q;
  logic [PROD_W-1:0]   prod_q, prod_raw;
  logic [PHASE_W-1:0]  high_len;

  logic      out_valid_q;
  out_beat_t out_q;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q      <= PPR_RST;
      rounds_q   <= ROUNDS_RST;
      interval_q <= INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PPR:      ppr_q      <= cfg_wdata_i[PPR_W-1:0];
        CFG_ROUNDS:   rounds_q   <= cfg_wdata_i[ROUNDS_W-1:0];
        CFG_INTERVAL: interval_q <= cfg_wdata_i[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // pot to rpm: divide by 4095 as shift plus one correction
  always_comb begin
    scaled = SCALED_W'(in_beat_i.pot_value * RPM_SPAN);
    q0     = scaled[SCALED_W-1:POT_W];
    r0     = {1'b0, scaled[POT_W-1:0]} + (POT_W+1)'(q0);
    rpm_d  = RPM_BASE + q0 + RPM_W'(r0 >= {1'b0, POT_FULL});
  end

  // one tick of the mover
  always_comb begin
    sens_d   = sens_q;
    last_d   = last_q;
    btn_d    = btn_q | in_beat_i.button_event;
    act_d    = act_q;
    dir_d    = dir_q;
    left_d   = left_q;
    hi_d     = hi_q;
    ptmr_d   = ptmr_q;
    slp_d    = slp_q;
    sleep    = 1'b0;
    start    = 1'b0;
    chk_clr  = 1'b0;
    go       = 1'b0;
    go_close = 1'b0;
    go_sleep = 1'b0;

    // idle: pending press first, else a due rain check
    if (!act_q) begin
      if (btn_d) begin
        btn_d    = 1'b0;
        sens_d   = ~sens_q;
        go       = 1'b1;
        go_close = sens_q;
        go_sleep = ~sens_q;
      end else if (sens_q && (ctmr_q >= interval_q)) begin
        chk_clr = 1'b1;
        if (in_beat_i.rain_level != last_q) begin
          last_d   = in_beat_i.rain_level;
          go       = 1'b1;
          go_close = ~in_beat_i.rain_level;
          go_sleep = in_beat_i.rain_level;
        end
      end
    end

    if (go) begin
      act_d  = 1'b1;
      dir_d  = go_close;
      slp_d  = go_sleep;
      left_d = PULSES_W'(rounds_q * ppr_q);
      hi_d   = 1'b0;
      ptmr_d = '0;
    end

    // pulse generator
    if (act_d) begin
      if ((ptmr_d == '0) && hi_d) begin
        hi_d   = 1'b0;
        ptmr_d = low_q;
      end
      if ((ptmr_d == '0) && !hi_d) begin
        if (left_d != '0) begin
          start  = 1'b1;
          hi_d   = 1'b1;
          left_d = left_d - 1'b1;
        end else begin
          act_d = 1'b0;
          sleep = slp_d;
          slp_d = 1'b0;
        end
      end
      if (act_d && !start && (ptmr_d != '0)) begin
        ptmr_d = ptmr_d - 1'b1;
      end
    end

    // free-running check timer, saturating
    if (chk_clr) begin
      ctmr_d = TIMER_W'(1);
    end else if (ctmr_q != TIMER_MAX) begin
      ctmr_d = ctmr_q + 1'b1;
    end else begin
      ctmr_d = ctmr_q;
    end
  end

  assign need_div_o = start;

  // speed product, zero forced to one
  always_comb begin
    prod_raw = PROD_W'(rpm_q * ppr_q);
  end

  assign high_len = quo_i[PHASE_W+1:2];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q      <= 1'b1;
      last_q      <= 1'b1;
      ctmr_q      <= '0;
      btn_q       <= 1'b0;
      act_q       <= 1'b0;
      dir_q       <= 1'b0;
      left_q      <= '0;
      hi_q        <= 1'b0;
      ptmr_q      <= '0;
      slp_q       <= 1'b0;
      low_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire_i) begin
        sens_q <= sens_d;
        last_q <= last_d;
        ctmr_q <= ctmr_d;
        btn_q  <= btn_d;
        act_q  <= act_d;
        dir_q  <= dir_d;
        left_q <= left_d;
        hi_q   <= hi_d;
        ptmr_q <= ptmr_d;
        slp_q  <= slp_d;
      end else if (cmd_i.load) begin
        // new pulse: high time runs down from this tick on
        ptmr_q <= (high_len == '0) ? '0 : high_len - 1'b1;
        low_q  <= quo_i[PHASE_W-1:0];
      end
      // result register
      if (in_fire_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      rpm_q                <= rpm_d;
      out_q.step_out       <= act_d & hi_d;
      out_q.dir_out        <= dir_d;
      out_q.motor_busy     <= act_d;
      out_q.sensing_on     <= sens_d;
      out_q.rain_seen      <= ~last_d;
      out_q.sleep_request  <= sleep;
    end
    if (cmd_i.mul_en) begin
      prod_q <= (prod_raw == '0) ? PROD_W'(1) : prod_raw;
    end
  end

  assign prod_o      = prod_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // sleep request only as an opening move ends
  a_sleep_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.sleep_request) |-> (!out_q.motor_busy && !out_q.dir_out))
    else $error("sleep request outside the end of an opening move");

  // timer load only lands on a running high phase
  a_load_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (act_q && hi_q))
    else $error("pulse timing loaded outside a high phase");

endmodule

// ----- rtl/rain_triggered_stepper_mover.sv -----
// rain-triggered stepper mover: one input beat per microsecond tick, one result each
// a tick that needs no new step pulse leaves the controller idle, result registered next cycle
// a tick that starts a step pulse holds off the next beat through the speed
// multiply, the one-bit-a-cycle divider and the timer load
// async active-low reset restores the register defaults: sensing on, dry, motor idle
// depends on rtsm_pkg, rtsm_in_if, rtsm_out_if, rtsm_div, rtsm_ctrl, rtsm_dp
module rain_triggered_stepper_mover import rtsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  rtsm_in_if.sink               in_i,
  rtsm_out_if.source            out_o
);

  logic              in_fire;
  logic              idle;
  logic              need_div;
  logic              div_done;
  logic              out_valid;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  cmd_t              cmd;
  sts_t              sts;

  // accept a beat when idle and the result slot frees up
  assign in_i.ready = idle && (!out_valid || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;

  assign sts.need_div = need_div;
  assign sts.div_done = div_done;

  rtsm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .idle_o    (idle)
  );

  rtsm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .in_beat_i   (in_i.data),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .quo_i       (quo),
    .need_div_o  (need_div),
    .prod_o      (prod),
    .out_valid_o (out_valid),
    .out_beat_o  (out_o.data)
  );

  rtsm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd.div_start),
    .divisor_i (prod),
    .done_o    (div_done),
    .quo_o     (quo)
  );

  assign out_o.valid = out_valid;

endmodule

// ----- dv/rtsm_tick_checker.sv -----
`timescale 1ns / 1ps
// result checker for the rain-triggered stepper mover: follows register writes, predicts
// one result beat per accepted tick beat and compares it with the result channel
// depends on rtsm_pkg, rtsm_in_if and rtsm_out_if
module rtsm_tick_checker import rtsm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  rtsm_in_if                    tick_i,
  rtsm_out_if                   result_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           awaited_count_o
);

  localparam int unsigned HIGH_NUMER = 12000000;
  localparam int unsigned MAX_LOGGED = 40;

  // register copies
  logic [PPR_W-1:0]    ppr_r;
  logic [ROUNDS_W-1:0] rounds_r;
  logic [TIMER_W-1:0]  interval_r;

  // mover state
  logic                sensing;
  logic                rain_last;   // 1 dry
  logic                press_held;
  logic                moving;
  logic                closing_dir;
  logic                pulse_high;
  logic                sleep_armed;
  logic [TIMER_W-1:0]  check_cnt;
  logic [PULSES_W-1:0] pulses_left;
  logic [PHASE_W-1:0]  phase_cnt;
  logic [PHASE_W-1:0]  low_len;

  out_beat_t   awaited_q [$];
  out_beat_t   want;
  out_beat_t   got;
  int unsigned n_mismatch = 0;
  int unsigned n_results = 0;

  // packed bit order of the result beat, lsb first
  string field_label [6] = '{"sleep_request", "rain_seen", "sensing_on",
                             "motor_busy", "dir_out", "step_out"};

  task automatic flag_mismatch(input string msg);
    n_mismatch++;
    // keep the log short when everything goes wrong
    if (n_mismatch <= MAX_LOGGED) begin
      $display("%0t mismatch: %s", $time, msg);
    end
  endtask

  function automatic void launch_move(input logic closing, input logic sleep_after);
    int unsigned total;
    total       = rounds_r * ppr_r;
    moving      = 1'b1;
    closing_dir = closing;
    sleep_armed = sleep_after;
    pulses_left = PULSES_W'(total);
    pulse_high  = 1'b0;
    phase_cnt   = '0;
  endfunction

  // speed from the pot, then high and low times of the new pulse
  function automatic void fire_pulse(input logic [POT_W-1:0] pot);
    int unsigned rpm;
    int unsigned prod;
    rpm  = RPM_BASE + pot * RPM_SPAN / POT_FULL;
    prod = rpm * ppr_r;
    if (prod == 0) begin
      prod = 1;
    end
    pulse_high  = 1'b1;
    phase_cnt   = PHASE_W'(HIGH_NUMER / prod);
    low_len     = PHASE_W'(LOW_NUMER / prod);
    pulses_left = pulses_left - 1'b1;
  endfunction

  // one microsecond tick of the mover
  function automatic out_beat_t advance_mover(input in_beat_t beat);
    out_beat_t res;
    logic      sleep;
    sleep = 1'b0;
    if (beat.button_event) begin
      press_held = 1'b1;
    end
    // a held press beats a due rain check
    if (!moving) begin
      if (press_held) begin
        press_held = 1'b0;
        sensing    = ~sensing;
        launch_move(~sensing, sensing);
      end else if (sensing && check_cnt >= interval_r) begin
        check_cnt = '0;
        if (beat.rain_level != rain_last) begin
          rain_last = beat.rain_level;
          launch_move(~beat.rain_level, beat.rain_level);
        end
      end
    end
    // pulse generator
    if (moving) begin
      if (phase_cnt == '0 && pulse_high) begin
        pulse_high = 1'b0;
        phase_cnt  = low_len;
      end
      if (phase_cnt == '0 && !pulse_high) begin
        if (pulses_left != '0) begin
          fire_pulse(beat.pot_value);
        end else begin
          moving      = 1'b0;
          sleep       = sleep_armed;
          sleep_armed = 1'b0;
        end
      end
      if (moving && phase_cnt != '0) begin
        phase_cnt = phase_cnt - 1'b1;
      end
    end
    if (check_cnt != TIMER_MAX) begin
      check_cnt = check_cnt + 1'b1;
    end
    res.step_out      = moving & pulse_high;
    res.dir_out       = closing_dir;
    res.motor_busy    = moving;
    res.sensing_on    = sensing;
    res.rain_seen     = ~rain_last;
    res.sleep_request = sleep;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_r       = PPR_RST;
      rounds_r    = ROUNDS_RST;
      interval_r  = INTERVAL_RST;
      sensing     = 1'b1;
      rain_last   = 1'b1;
      press_held  = 1'b0;
      moving      = 1'b0;
      closing_dir = 1'b0;
      pulse_high  = 1'b0;
      sleep_armed = 1'b0;
      check_cnt   = '0;
      pulses_left = '0;
      phase_cnt   = '0;
      low_len     = '0;
      awaited_q.delete();
      mismatch_count_o <= 0;
      awaited_count_o  <= 0;
    end else begin
      // register writes, upper bits dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PPR:      ppr_r      = cfg_wdata_i[PPR_W-1:0];
          CFG_ROUNDS:   rounds_r   = cfg_wdata_i[ROUNDS_W-1:0];
          CFG_INTERVAL: interval_r = cfg_wdata_i[TIMER_W-1:0];
          default: ;
        endcase
      end
      // result beat against the oldest prediction
      if (result_i.valid && result_i.ready) begin
        if (awaited_q.size() == 0) begin
          flag_mismatch($sformatf("result beat %0d arrived with nothing awaited", n_results));
        end else begin
          want = awaited_q.pop_front();
          got  = result_i.data;
          for (int i = 0; i < $bits(out_beat_t); i++) begin
            if (got[i] !== want[i]) begin
              flag_mismatch($sformatf("result beat %0d %s: got %b, predicted %b",
                                      n_results, field_label[i], got[i], want[i]));
            end
          end
        end
        n_results++;
      end
      // new tick beat
      if (tick_i.valid && tick_i.ready) begin
        awaited_q.push_back(advance_mover(tick_i.data));
      end
      mismatch_count_o <= n_mismatch;
      awaited_count_o  <= awaited_q.size();
    end
  end

endmodule

// ----- dv/rain_triggered_stepper_mover_test.sv -----
`timescale 1ns / 1ps
// stimulus and verdict for the rain-triggered stepper mover: directed ticks, random phases
// of zero-length moves and a closing stretch with real step pulses under random idling
// depends on rtsm_pkg, rtsm_in_if, rtsm_out_if, the mover and rtsm_tick_checker
module rain_triggered_stepper_mover_test;
  import rtsm_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // unused register index, writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned ZERO_PHASES   = 6;
  localparam int unsigned ZERO_TICKS    = 40;
  localparam int unsigned MOVE_PHASES   = 2;
  localparam int unsigned MOVE_TICKS    = 160;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned cycle_count;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        rain_now;

  rtsm_in_if  tick_ch ();
  rtsm_out_if result_ch ();

  rain_triggered_stepper_mover i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (tick_ch),
    .out_o       (result_ch)
  );

  rtsm_tick_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .tick_i           (tick_ch),
    .result_i         (result_ch),
    .mismatch_count_o (mismatches),
    .awaited_count_o  (awaited)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        idle_pct  = 57;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        idle_pct  = 0;
        stall_pct = 57;
      end
      default: begin
        idle_pct  = 29;
        stall_pct = 29;
      end
    endcase
  endtask

  // one tick beat, with random sender gaps in front
  task automatic send_tick(input logic rain, input logic press, input logic [POT_W-1:0] pot);
    in_beat_t beat;
    beat.rain_level   = rain;
    beat.button_event = press;
    beat.pot_value    = pot;
    while ($urandom_range(0, 99) < idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= beat;
    do @(posedge clk_i); while (!tick_ch.ready);
  endtask

  // stop sending and wait for every predicted result beat
  task automatic drain();
    tick_ch.valid <= 1'b0;
    do @(posedge clk_i); while (awaited != 0);
  endtask

  // all three registers, with junk above the ppr and rounds widths and a write to the spare index
  task automatic load_setting(input int unsigned ppr, input int unsigned rounds,
                              input int unsigned interval);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SPARE;
    cfg_wdata_i <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_PPR;
    cfg_wdata_i <= CFG_DATA_W'({$urandom, PPR_W'(ppr)});
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ROUNDS;
    cfg_wdata_i <= CFG_DATA_W'({$urandom, ROUNDS_W'(rounds)});
    @(posedge clk_i);
    cfg_idx_i   <= CFG_INTERVAL;
    cfg_wdata_i <= CFG_DATA_W'(interval);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [POT_W-1:0] pot;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_PPR;
    cfg_wdata_i   <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.data  <= '0;
    rain_now = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: long interval, so no rain check yet
    set_idling(IDLE_NONE);
    send_tick(1'b1, 1'b0, '0);
    send_tick(1'b0, 1'b0, '1);
    drain();

    // zero pulses per round, check on every idle tick
    load_setting(0, 100, 0);
    send_tick(1'b0, 1'b0, '1);          // wet: closing move, ends at once
    send_tick(1'b1, 1'b0, '0);          // dry: opening move and sleep request
    send_tick(1'b1, 1'b1, 12'h800);     // press: sensing off, closing move
    send_tick(1'b0, 1'b0, 12'h7ff);     // sensing off, rain ignored
    send_tick(1'b0, 1'b1, 12'haaa);     // press: sensing on, opening move
    send_tick(1'b1, 1'b1, 12'h555);     // press: sensing off, closing move, rain unchanged
    send_tick(1'b1, 1'b1, '0);
    drain();

    // zero rounds, short interval with the rain flipping every tick
    load_setting(1023, 0, 3);
    for (int i = 0; i < 8; i++) begin
      send_tick(i[0], 1'b0, POT_W'($urandom));
    end
    drain();

    // longest interval: only presses cause moves
    load_setting(1, 0, 24'hffffff);
    send_tick(1'b0, 1'b1, '0);
    send_tick(1'b1, 1'b0, '1);
    send_tick(1'b0, 1'b1, '0);

    // random phases of zero-length moves
    for (int p = 0; p < ZERO_PHASES; p++) begin
      drain();
      set_idling(idle_mode_e'(p % 4));
      if ($urandom_range(0, 1) == 1) begin
        load_setting(0, $urandom_range(0, 127), $urandom_range(0, 20));
      end else begin
        load_setting($urandom_range(0, 1023), 0, $urandom_range(0, 20));
      end
      for (int k = 0; k < ZERO_TICKS; k++) begin
        if ($urandom_range(0, 99) < 30) begin
          rain_now = ~rain_now;
        end
        send_tick(rain_now, $urandom_range(0, 99) < 10, POT_W'($urandom));
      end
    end

    // real move to finish: a press starts it, later presses are held pending
    for (int p = 0; p < MOVE_PHASES; p++) begin
      drain();
      set_idling(idle_mode_e'((ZERO_PHASES + p) % 4));
      load_setting((p == 0) ? 1023 : $urandom_range(512, 1023), $urandom_range(1, 127),
                   $urandom_range(0, 8));
      if (p == 0) begin
        send_tick(rain_now, 1'b1, '1);
      end
      for (int k = 0; k < MOVE_TICKS; k++) begin
        if ($urandom_range(0, 99) < 20) begin
          rain_now = ~rain_now;
        end
        // mostly fast speeds so that several pulses start
        pot = ($urandom_range(0, 3) != 0) ? POT_W'($urandom_range(3500, 4095))
                                          : POT_W'($urandom);
        send_tick(rain_now, $urandom_range(0, 99) < 5, pot);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- rain_triggered_stepper_mover.f -----
rtl/rtsm_pkg.sv
rtl/rtsm_in_if.sv
rtl/rtsm_out_if.sv
rtl/rtsm_div.sv
rtl/rtsm_ctrl.sv
rtl/rtsm_dp.sv
rtl/rain_triggered_stepper_mover.sv
dv/rtsm_tick_checker.sv
dv/rain_triggered_stepper_mover_test.sv
